// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define GDFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// trigger in one cycle, consequence in the next
`define GDFS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) \
    else $error(msg);

`endif

// ===== sv/gdfs_pkg.sv =====
package gdfs_pkg;

  localparam int CRD_W        = 4;
  localparam int GRID_SIDE_DEF = 16;
  localparam int CFG_AW       = 3;

  // register indexes on the write port
  localparam logic [CFG_AW-1:0] REG_LIMIT   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_START_X = 3'd1;
  localparam logic [CFG_AW-1:0] REG_START_Y = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GOAL_X  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GOAL_Y  = 3'd4;

  localparam logic [CRD_W-1:0] LIMIT_RST   = 4'd10;
  localparam logic [CRD_W-1:0] START_X_RST = 4'd2;
  localparam logic [CRD_W-1:0] START_Y_RST = 4'd2;
  localparam logic [CRD_W-1:0] GOAL_X_RST  = 4'd10;
  localparam logic [CRD_W-1:0] GOAL_Y_RST  = 4'd10;

  typedef enum logic [1:0] {
    ACT_MARK,
    ACT_CLEAR,
    ACT_BEGIN,
    ACT_STEP
  } gdfs_action_t;

  typedef enum logic [1:0] {
    STS_PATH,
    STS_GOAL,
    STS_NOPATH,
    STS_IDLE
  } gdfs_status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEARCH,
    PH_DONE
  } gdfs_phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_EMIT1,
    ST_EMIT2
  } gdfs_state_t;

  // neighbor candidate from the shared test unit
  typedef struct packed {
    logic             inb;
    logic             goal;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
  } gdfs_nbr_t;

  localparam logic [CRD_W:0] D_ZERO = 5'd0;
  localparam logic [CRD_W:0] D_POS  = 5'd1;
  localparam logic [CRD_W:0] D_NEG  = 5'h1f;

  // neighbor order: y+1, x+1, y-1, x-1, then the four diagonals
  function automatic logic [CRD_W:0] dir_dx(input logic [2:0] d);
    logic [CRD_W:0] r;
    case (d)
      3'd0:    r = D_ZERO;
      3'd1:    r = D_POS;
      3'd2:    r = D_ZERO;
      3'd3:    r = D_NEG;
      3'd4:    r = D_POS;
      3'd5:    r = D_POS;
      3'd6:    r = D_NEG;
      default: r = D_NEG;
    endcase
    return r;
  endfunction

  function automatic logic [CRD_W:0] dir_dy(input logic [2:0] d);
    logic [CRD_W:0] r;
    case (d)
      3'd0:    r = D_POS;
      3'd1:    r = D_ZERO;
      3'd2:    r = D_NEG;
      3'd3:    r = D_ZERO;
      3'd4:    r = D_NEG;
      3'd5:    r = D_POS;
      3'd6:    r = D_NEG;
      default: r = D_POS;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/gdfs_ram.sv =====
module gdfs_ram #(
  parameter int Width = 1,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gdfs_nbr.sv =====
module gdfs_nbr import gdfs_pkg::*; (
  input  logic [CRD_W-1:0] cur_x,
  input  logic [CRD_W-1:0] cur_y,
  input  logic [2:0]       dir,
  input  logic [CRD_W-1:0] lim,
  input  logic [CRD_W-1:0] goal_x,
  input  logic [CRD_W-1:0] goal_y,
  output gdfs_nbr_t        nb
);

  logic [CRD_W:0] nx;
  logic [CRD_W:0] ny;
  logic           inb;

  // top bit set means the step went below zero or past the coordinate range
  assign nx  = {1'b0, cur_x} + dir_dx(dir);
  assign ny  = {1'b0, cur_y} + dir_dy(dir);
  assign inb = !nx[CRD_W] && !ny[CRD_W] &&
               (nx[CRD_W-1:0] <= lim) && (ny[CRD_W-1:0] <= lim);

  always_comb begin
    nb.inb  = inb;
    nb.goal = inb && (nx[CRD_W-1:0] == goal_x) && (ny[CRD_W-1:0] == goal_y);
    nb.x    = nx[CRD_W-1:0];
    nb.y    = ny[CRD_W-1:0];
  end

endmodule

// ===== sv/grid_depth_first_path_search.sv =====
// channel  | direction | tvalid/tready            | payload
// in_      | request   | in_tvalid / in_tready    | tuser: action, tdata: cell_x, cell_y
// out_     | result    | out_tvalid / out_tready  | tuser: status, tlast: last,
//          |           |                          | tdata: path_x, path_y
// cfg_     | write     | cfg_we                   | cfg_addr, cfg_wdata
//
// mark sets the obstacle cell on accept. clear and begin: accept, then sweep all
// 2^(2*CW) cells (256 at GRID_SIDE 16). step: accept, scan the eight neighbors
// through the single neighbor test unit (a goal ends the scan), pop on a dead end, emit
// one or two results; a step while not searching or on the goal emits one result
// reset runs the same sweep over the obstacle and seen maps, in_tready stays low meanwhile
// a stalled output register holds the step in its emit state until out_tready
module grid_depth_first_path_search import gdfs_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // cell_x, cell_y
  input  logic [1:0]        in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // path_x, path_y
  output logic [1:0]        out_tuser,  // status
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CRD_W-1:0]  cfg_wdata
);

  localparam int CW    = (GRID_SIDE > 16) ? CRD_W : $clog2(GRID_SIDE);
  localparam int AW    = 2 * CW;
  localparam int CELLS = 1 << AW;
  localparam logic [CRD_W-1:0] SIDE_MAX =
    CRD_W'((GRID_SIDE > 16) ? 15 : GRID_SIDE - 1);

  gdfs_state_t state_r, state_nxt;
  gdfs_phase_t phase_r, phase_nxt;

  logic [CRD_W-1:0] lim_r, sx_r, sy_r, gx_r, gy_r;
  logic [CW-1:0]    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic             clr_obs_r, clr_obs_nxt, clr_seen_r, clr_seen_nxt;
  logic [3:0]       scan_r, scan_nxt;
  logic             pushed_r, pushed_nxt;
  logic [AW-1:0]    top_r, top_nxt;
  logic             ev_vld_r, ev_vld_nxt, ev_goal_r, ev_goal_nxt;
  logic [AW-1:0]    ev_addr_r, ev_addr_nxt;

  logic [CRD_W-1:0] r1_x_r, r1_x_nxt, r1_y_r, r1_y_nxt;
  gdfs_status_t     r1_st_r, r1_st_nxt;
  logic             r1_last_r, r1_last_nxt;
  logic             r2_goal_r, r2_goal_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [CRD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  gdfs_status_t     out_st_r, out_st_nxt;
  logic             out_last_r, out_last_nxt;

  logic             obs_we, obs_wd, obs_rd;
  logic [AW-1:0]    obs_wa;
  logic             seen_we, seen_wd, seen_rd;
  logic [AW-1:0]    seen_wa;
  logic             stk_we;
  logic [AW-1:0]    stk_ra, stk_rd;

  gdfs_nbr_t        nb;
  logic [AW-1:0]    nb_addr;
  logic [CRD_W-1:0] lim_eff, cur4_x, cur4_y;
  gdfs_action_t     act;
  logic             in_acc, cell_ok, start_ok, at_goal, push, scan_end;
  logic             out_free, sweep_end;
  logic [AW-1:0]    cnt_dec, new_top;

  assign lim_eff  = (lim_r > SIDE_MAX) ? SIDE_MAX : lim_r;
  assign cur4_x   = CRD_W'(cur_x_r);
  assign cur4_y   = CRD_W'(cur_y_r);
  assign act      = gdfs_action_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign cell_ok  = (32'(in_tdata[CRD_W-1:0]) < GRID_SIDE) &&
                    (32'(in_tdata[2*CRD_W-1:CRD_W]) < GRID_SIDE);
  assign start_ok = (32'(sx_r) < GRID_SIDE) && (32'(sy_r) < GRID_SIDE);
  assign at_goal  = (cur4_x == gx_r) && (cur4_y == gy_r);
  assign push     = (state_r == ST_SCAN) && ev_vld_r && !obs_rd && !seen_rd;
  assign scan_end = scan_r[3];
  assign cnt_dec  = cnt_r - AW'(cnt_r != '0);
  assign new_top  = push ? ev_addr_r : top_r;
  assign stk_ra   = cnt_dec - AW'(1);
  assign out_free = !out_vld_r || out_tready;
  assign sweep_end = (sweep_r == '1);
  assign nb_addr  = {nb.y[CW-1:0], nb.x[CW-1:0]};

  // the one neighbor test unit, stepped through the eight directions
  gdfs_nbr u_nbr (
    .cur_x  (cur4_x),
    .cur_y  (cur4_y),
    .dir    (scan_r[2:0]),
    .lim    (lim_eff),
    .goal_x (gx_r),
    .goal_y (gy_r),
    .nb     (nb)
  );

  gdfs_ram #(.Width(1), .Depth(CELLS)) u_obs (
    .clk   (clk),
    .we    (obs_we),
    .waddr (obs_wa),
    .wdata (obs_wd),
    .raddr (nb_addr),
    .rdata (obs_rd)
  );

  gdfs_ram #(.Width(1), .Depth(CELLS)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_wa),
    .wdata (seen_wd),
    .raddr (nb_addr),
    .rdata (seen_rd)
  );

  gdfs_ram #(.Width(AW), .Depth(CELLS)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt_r),
    .wdata (ev_addr_r),
    .raddr (stk_ra),
    .rdata (stk_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sweep_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (act inside {ACT_CLEAR, ACT_BEGIN}) begin
            state_nxt = ST_CLEAR;
          end else if (act == ACT_STEP) begin
            state_nxt = (phase_r != PH_SEARCH || at_goal) ? ST_EMIT1 : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (push && ev_goal_r) begin
          state_nxt = ST_EMIT1;
        end else if (scan_end) begin
          if (pushed_r || push || cnt_dec == '0) state_nxt = ST_EMIT1;
          else state_nxt = ST_POP;
        end
      end
      ST_POP: state_nxt = ST_EMIT1;
      ST_EMIT1: begin
        if (out_free) state_nxt = r1_last_r ? ST_IDLE : ST_EMIT2;
      end
      ST_EMIT2: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    cnt_nxt      = cnt_r;
    sweep_nxt    = sweep_r;
    clr_obs_nxt  = clr_obs_r;
    clr_seen_nxt = clr_seen_r;
    scan_nxt     = scan_r;
    pushed_nxt   = pushed_r;
    top_nxt      = top_r;
    ev_vld_nxt   = ev_vld_r;
    ev_goal_nxt  = ev_goal_r;
    ev_addr_nxt  = ev_addr_r;
    r1_x_nxt     = r1_x_r;
    r1_y_nxt     = r1_y_r;
    r1_st_nxt    = r1_st_r;
    r1_last_nxt  = r1_last_r;
    r2_goal_nxt  = r2_goal_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    obs_we       = 1'b0;
    obs_wa       = sweep_r;
    obs_wd       = 1'b0;
    seen_we      = 1'b0;
    seen_wa      = sweep_r;
    seen_wd      = 1'b0;
    stk_we       = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        obs_we    = clr_obs_r;
        seen_we   = clr_seen_r;
        // the start cell comes out of the sweep already seen
        seen_wd   = (phase_r == PH_SEARCH) && (sweep_r == {cur_y_r, cur_x_r});
        sweep_nxt = sweep_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_MARK: begin
              obs_we = cell_ok;
              obs_wa = {in_tdata[CRD_W +: CW], in_tdata[CW-1:0]};
              obs_wd = 1'b1;
            end
            ACT_CLEAR: begin
              clr_obs_nxt  = 1'b1;
              clr_seen_nxt = 1'b0;
              sweep_nxt    = '0;
            end
            ACT_BEGIN: begin
              clr_obs_nxt  = 1'b0;
              clr_seen_nxt = 1'b1;
              sweep_nxt    = '0;
              cnt_nxt      = '0;
              if (start_ok) begin
                cur_x_nxt = sx_r[CW-1:0];
                cur_y_nxt = sy_r[CW-1:0];
                phase_nxt = PH_SEARCH;
              end else begin
                cur_x_nxt = '0;
                cur_y_nxt = '0;
                phase_nxt = PH_DONE;
              end
            end
            ACT_STEP: begin
              r1_x_nxt    = cur4_x;
              r1_y_nxt    = cur4_y;
              r1_st_nxt   = STS_PATH;
              r1_last_nxt = 1'b1;
              scan_nxt    = '0;
              ev_vld_nxt  = 1'b0;
              pushed_nxt  = 1'b0;
              if (phase_r != PH_SEARCH) begin
                r1_x_nxt  = '0;
                r1_y_nxt  = '0;
                r1_st_nxt = STS_IDLE;
              end else if (at_goal) begin
                r1_st_nxt = STS_GOAL;
                phase_nxt = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // evaluate the candidate read last cycle, issue the next one
        if (push) begin
          seen_we    = 1'b1;
          seen_wa    = ev_addr_r;
          seen_wd    = 1'b1;
          stk_we     = 1'b1;
          cnt_nxt    = cnt_r + AW'(1);
          top_nxt    = ev_addr_r;
          pushed_nxt = 1'b1;
        end
        if (push && ev_goal_r) begin
          phase_nxt   = PH_DONE;
          r1_last_nxt = 1'b0;
          r2_goal_nxt = 1'b1;
        end else if (!scan_end) begin
          ev_vld_nxt  = nb.inb;
          ev_goal_nxt = nb.goal;
          ev_addr_nxt = nb_addr;
          scan_nxt    = scan_r + 4'd1;
        end else if (pushed_r || push) begin
          cur_x_nxt   = new_top[CW-1:0];
          cur_y_nxt   = new_top[AW-1:CW];
          r1_last_nxt = 1'b1;
        end else begin
          // dead end
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            phase_nxt   = PH_DONE;
            r1_last_nxt = 1'b0;
            r2_goal_nxt = 1'b0;
          end
        end
      end
      ST_POP: begin
        cur_x_nxt   = stk_rd[CW-1:0];
        cur_y_nxt   = stk_rd[AW-1:CW];
        r1_last_nxt = 1'b1;
      end
      ST_EMIT1: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_x_nxt    = r1_x_r;
          out_y_nxt    = r1_y_r;
          out_st_nxt   = r1_st_r;
          out_last_nxt = r1_last_r;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_x_nxt    = r2_goal_r ? gx_r : '0;
          out_y_nxt    = r2_goal_r ? gy_r : '0;
          out_st_nxt   = r2_goal_r ? STS_GOAL : STS_NOPATH;
          out_last_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      phase_r    <= PH_IDLE;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      cnt_r      <= '0;
      sweep_r    <= '0;
      clr_obs_r  <= 1'b1;
      clr_seen_r <= 1'b1;
      scan_r     <= '0;
      pushed_r   <= 1'b0;
      ev_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      cnt_r      <= cnt_nxt;
      sweep_r    <= sweep_nxt;
      clr_obs_r  <= clr_obs_nxt;
      clr_seen_r <= clr_seen_nxt;
      scan_r     <= scan_nxt;
      pushed_r   <= pushed_nxt;
      ev_vld_r   <= ev_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RST;
      sx_r  <= START_X_RST;
      sy_r  <= START_Y_RST;
      gx_r  <= GOAL_X_RST;
      gy_r  <= GOAL_Y_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LIMIT:   lim_r <= cfg_wdata;
        REG_START_X: sx_r  <= cfg_wdata;
        REG_START_Y: sy_r  <= cfg_wdata;
        REG_GOAL_X:  gx_r  <= cfg_wdata;
        REG_GOAL_Y:  gy_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    ev_goal_r  <= ev_goal_nxt;
    ev_addr_r  <= ev_addr_nxt;
    r1_x_r     <= r1_x_nxt;
    r1_y_r     <= r1_y_nxt;
    r1_st_r    <= r1_st_nxt;
    r1_last_r  <= r1_last_nxt;
    r2_goal_r  <= r2_goal_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/gdfs_checker.sv =====
`include "assert_macros.svh"

module gdfs_checker import gdfs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  `GDFS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `GDFS_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  // no-path and idle results close a request and carry no cell
  `GDFS_ASSERT(a_end_codes, out_tvalid && (out_tuser == STS_NOPATH || out_tuser == STS_IDLE) |-> out_tlast && (out_tdata == 8'd0), "end result not last or not zero")
  // only a path cell can be followed by a second result
  `GDFS_ASSERT(a_first_is_path, out_tvalid && !out_tlast |-> out_tuser == STS_PATH, "non-last result is not a path cell")

endmodule

bind grid_depth_first_path_search gdfs_checker u_gdfs_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gdfs_pkg::*;

  localparam int ITEMS        = 1950;
  localparam int SETTLE       = 320;      // clear/begin sweep covers 256 cells
  localparam int LIMIT_CYCLES = 2000000;
  localparam int STEP_CAP     = 600;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    gdfs_status_t     st;
    logic             last;
  } path_res_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_REQ,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_AW-1:0] reg_idx;
    logic [CRD_W-1:0]  reg_val;
    gdfs_action_t      act;
    logic [CRD_W-1:0]  cx;
    logic [CRD_W-1:0]  cy;
    logic [CRD_W-1:0]  ex;
    logic [CRD_W-1:0]  ey;
    gdfs_status_t      est;
  } plan_row_t;

  localparam int PLAN_LEN = 38;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // cell_x, cell_y
  logic [1:0]        in_tuser = '0;   // action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // path_x, path_y
  logic [1:0]        out_tuser;       // status
  logic              out_tlast;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CRD_W-1:0]  cfg_wdata = '0;

  grid_depth_first_path_search u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // search mirror
  logic [CRD_W-1:0] bound = LIMIT_RST;
  logic [CRD_W-1:0] from_x = START_X_RST;
  logic [CRD_W-1:0] from_y = START_Y_RST;
  logic [CRD_W-1:0] to_x = GOAL_X_RST;
  logic [CRD_W-1:0] to_y = GOAL_Y_RST;
  bit               blocked [256];
  bit               visited [256];
  logic [7:0]       trail [256];
  int               trail_len = 0;
  logic [7:0]       here = '0;
  gdfs_phase_t      walk_phase = PH_IDLE;
  int               nbr_dx [8] = '{0, 1, 0, -1, 1, 1, -1, -1};
  int               nbr_dy [8] = '{1, 0, -1, 0, -1, 1, -1, 1};

  path_res_t        step_out [2];
  int               n_out;
  path_res_t        expected_cells [$];

  int               errors = 0;
  int               n_sent = 0;
  int               cycles = 0;
  bit               held = 1'b0;
  bit               quiet_tx = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_TYPED, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_IDLE},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_MARK, 4'd15, 4'd15, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_CLEAR, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_BEGIN, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    // start on the goal
    '{ROW_REG, REG_START_X, 4'd5, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_START_Y, 4'd5, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_X, 4'd5, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_Y, 4'd5, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_BEGIN, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_TYPED, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd5, 4'd5, STS_GOAL},
    '{ROW_TYPED, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_IDLE},
    // single cell grid, immediate dead end
    '{ROW_REG, REG_LIMIT, 4'd0, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_START_X, 4'd0, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_START_Y, 4'd0, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_X, 4'd15, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_Y, 4'd15, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_BEGIN, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    // goal sits on an obstacle, search pops back to empty
    '{ROW_REG, REG_LIMIT, 4'd1, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_X, 4'd1, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_Y, 4'd1, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_MARK, 4'd1, 4'd1, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_BEGIN, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    // far corner, goal one diagonal away
    '{ROW_REG, REG_LIMIT, 4'd15, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_START_X, 4'd15, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_START_Y, 4'd15, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_X, 4'd14, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REG, REG_GOAL_Y, 4'd14, ACT_MARK, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_CLEAR, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_BEGIN, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_REQ, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_PATH},
    '{ROW_TYPED, REG_LIMIT, 4'd0, ACT_STEP, 4'd0, 4'd0, 4'd0, 4'd0, STS_IDLE}
  };

  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CRD_W-1:0] pick_coord(input int lim);
    if ($urandom_range(0, 7) == 0) return CRD_W'($urandom_range(0, 15));
    return CRD_W'($urandom_range(0, lim));
  endfunction

  task automatic add_out(input int x, input int y, input gdfs_status_t st, input logic last);
    step_out[n_out] = '{x: CRD_W'(x), y: CRD_W'(y), st: st, last: last};
    n_out++;
  endtask

  // one request through the search mirror, results land in step_out
  task automatic advance_walk(input gdfs_action_t act, input logic [3:0] cx,
                              input logic [3:0] cy);
    int  curx, cury, nx, ny, idx, d;
    bit  pushed, hit;
    n_out = 0;
    case (act)
      ACT_MARK: blocked[{cy, cx}] = 1'b1;
      ACT_CLEAR: foreach (blocked[i]) blocked[i] = 1'b0;
      ACT_BEGIN: begin
        foreach (visited[i]) visited[i] = 1'b0;
        trail_len = 0;
        here = {from_y, from_x};
        visited[here] = 1'b1;
        walk_phase = PH_SEARCH;
      end
      default: begin
        curx = here[3:0];
        cury = here[7:4];
        if (walk_phase != PH_SEARCH) begin
          add_out(0, 0, STS_IDLE, 1'b1);
        end else if (curx == to_x && cury == to_y) begin
          add_out(curx, cury, STS_GOAL, 1'b1);
          walk_phase = PH_DONE;
        end else begin
          pushed = 1'b0;
          hit = 1'b0;
          for (d = 0; d < 8; d++) begin
            nx = curx + nbr_dx[d];
            ny = cury + nbr_dy[d];
            if (nx < 0 || ny < 0 || nx > bound || ny > bound) continue;
            idx = ny * 16 + nx;
            if (blocked[idx] || visited[idx]) continue;
            visited[idx] = 1'b1;
            if (trail_len < 256) begin
              trail[trail_len] = idx[7:0];
              trail_len++;
            end
            pushed = 1'b1;
            if (nx == to_x && ny == to_y) begin
              hit = 1'b1;
              break;
            end
          end
          if (hit) begin
            add_out(curx, cury, STS_PATH, 1'b0);
            add_out(nx, ny, STS_GOAL, 1'b1);
            walk_phase = PH_DONE;
          end else begin
            // dead end backs up one level
            if (!pushed && trail_len > 0) trail_len--;
            if (trail_len == 0) begin
              add_out(curx, cury, STS_PATH, 1'b0);
              add_out(0, 0, STS_NOPATH, 1'b1);
              walk_phase = PH_DONE;
            end else begin
              here = trail[trail_len - 1];
              add_out(curx, cury, STS_PATH, 1'b1);
            end
          end
        end
      end
    endcase
  endtask

  task automatic issue_request(input gdfs_action_t act, input logic [3:0] cx,
                               input logic [3:0] cy, input bit typed,
                               input path_res_t fixed);
    int gap;
    gap = gap_len(quiet_tx);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {cy, cx};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    advance_walk(act, cx, cy);
    if (typed) begin
      expected_cells = {expected_cells, fixed};
    end else begin
      for (int i = 0; i < n_out; i++) expected_cells = {expected_cells, step_out[i]};
    end
  endtask

  task automatic send(input gdfs_action_t act, input logic [3:0] cx, input logic [3:0] cy);
    issue_request(act, cx, cy, 1'b0, '0);
  endtask

  task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [CRD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LIMIT:   bound = val;
      REG_START_X: from_x = val;
      REG_START_Y: from_y = val;
      REG_GOAL_X:  to_x = val;
      REG_GOAL_Y:  to_y = val;
      default: ;
    endcase
  endtask

  // block idle: all results in, then let a clear/begin sweep finish
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result receiver with random backpressure and one long hold
  initial begin
    int  stall_left;
    bit  quiet_rx;
    stall_left = 0;
    quiet_rx = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 300 && in_tvalid && expected_cells.size() > 0) begin
        held = 1'b1;
        stall_left = 600;
      end
      if ($urandom_range(0, 299) == 0) quiet_rx = !quiet_rx;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = gap_len(quiet_rx);
      end
    end
  end

  always @(posedge clk) begin
    path_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t unexpected result: x=%0d y=%0d status=%0d last=%0d", $time,
                 out_tdata[3:0], out_tdata[7:4], out_tuser, out_tlast);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_tdata[3:0] !== want.x) begin
          $display("%0t path_x: expected %0d, got %0d", $time, want.x, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[7:4] !== want.y) begin
          $display("%0t path_y: expected %0d, got %0d", $time, want.y, out_tdata[7:4]);
          errors++;
        end
        if (out_tuser !== want.st) begin
          $display("%0t status: expected %0d, got %0d", $time, want.st, out_tuser);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t last: expected %0d, got %0d", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("grid_depth_first_path_search: mismatch");
      $finish;
    end
  end

  initial begin
    bit               in_cfg;
    int               lim, steps, r;
    plan_row_t        row;
    logic [CRD_W-1:0] sx, sy;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    in_cfg = 1'b0;
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        if (!in_cfg) wait_quiet();
        set_reg(row.reg_idx, row.reg_val);
        in_cfg = 1'b1;
      end else begin
        issue_request(row.act, row.cx, row.cy, row.kind == ROW_TYPED,
                      '{x: row.ex, y: row.ey, st: row.est, last: 1'b1});
        in_cfg = 1'b0;
      end
    end

    while (n_sent < ITEMS) begin
      wait_quiet();
      r = $urandom_range(0, 9);
      lim = (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(1, 6);
      sx = pick_coord(lim);
      sy = pick_coord(lim);
      set_reg(REG_LIMIT, CRD_W'(lim));
      set_reg(REG_START_X, sx);
      set_reg(REG_START_Y, sy);
      if ($urandom_range(0, 9) == 0) begin
        set_reg(REG_GOAL_X, sx);
        set_reg(REG_GOAL_Y, sy);
      end else begin
        set_reg(REG_GOAL_X, pick_coord(lim));
        set_reg(REG_GOAL_Y, pick_coord(lim));
      end
      quiet_tx = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: any action in any order
        repeat ($urandom_range(4, 12))
          send(gdfs_action_t'($urandom_range(0, 3)), CRD_W'($urandom_range(0, 15)),
               CRD_W'($urandom_range(0, 15)));
      end else begin
        if ($urandom_range(0, 2) == 0) send(ACT_CLEAR, 4'd0, 4'd0);
        repeat ($urandom_range(0, lim + 2)) send(ACT_MARK, pick_coord(lim), pick_coord(lim));
        send(ACT_BEGIN, CRD_W'($urandom_range(0, 15)), CRD_W'($urandom_range(0, 15)));
        steps = 0;
        while (walk_phase == PH_SEARCH && steps < STEP_CAP) begin
          r = $urandom_range(0, 99);
          if (r < 6) send(ACT_MARK, pick_coord(lim), pick_coord(lim));
          else if (r == 6) send(ACT_BEGIN, 4'd0, 4'd0);
          else if (r == 7) send(ACT_CLEAR, 4'd0, 4'd0);
          else send(ACT_STEP, CRD_W'($urandom_range(0, 15)), CRD_W'($urandom_range(0, 15)));
          steps++;
        end
        repeat ($urandom_range(0, 2)) send(ACT_STEP, 4'd0, 4'd0);
      end
    end

    wait_quiet();
    if (errors == 0) begin
      $display("grid_depth_first_path_search: match");
    end else begin
      $display("grid_depth_first_path_search: mismatch");
    end
    $finish;
  end

endmodule
